// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the box collision test.
// Included by the modules that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define BVS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("box collision test: assertion failed");
// Checked at every clock edge, reset included.
`define BVS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("box collision test: assertion failed");
`else
`define BVS_ASSERT(lbl, prop)
`define BVS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/bvs_pkg.sv -----
// Types, codes and sizes of the box collision test.
// No dependencies; imported by every other RTL file except assert_macros.svh.
`default_nettype none
package bvs_pkg;
	localparam int MAX_SHAPES     = 16;
	localparam int MAX_VERTS      = 8;
	localparam int POLY_MIN_VERTS = 3;
	localparam int SW   = $clog2(MAX_SHAPES);
	localparam int CNTW = $clog2(MAX_SHAPES + 1);
	localparam int VIW  = $clog2(MAX_VERTS);
	localparam int VCW  = $clog2(MAX_VERTS + 1);
	localparam int VAW  = SW + VIW;
	localparam int OPW  = 19;
	localparam int PW   = 2 * OPW;

	typedef logic        [1:0]      mode_t;
	typedef logic        [1:0]      kind_t;
	typedef logic signed [15:0]     coord_t;
	typedef logic        [14:0]     ext_t;
	typedef logic        [1:0]      verdict_t;
	typedef logic        [3:0]      hit_t;
	typedef logic        [4:0]      total_t;
	typedef logic        [2:0]      cfg_idx_t;
	typedef logic        [15:0]     cfg_data_t;
	typedef logic signed [OPW-1:0]  opnd_t;
	typedef logic signed [PW-1:0]   prod_t;
	typedef logic        [VAW-1:0]  vaddr_t;
	typedef logic        [31:0]     vdata_t;

	localparam mode_t MODE_CLEAR  = 2'd0;
	localparam mode_t MODE_ADD    = 2'd1;
	localparam mode_t MODE_APPEND = 2'd2;
	localparam mode_t MODE_QUERY  = 2'd3;

	localparam kind_t KIND_RECT   = 2'd0;
	localparam kind_t KIND_CIRCLE = 2'd1;
	localparam kind_t KIND_POLY   = 2'd2;

	localparam verdict_t VERDICT_OK       = 2'd0;
	localparam verdict_t VERDICT_OUTSIDE  = 2'd1;
	localparam verdict_t VERDICT_HIT      = 2'd2;
	localparam verdict_t VERDICT_OVERFLOW = 2'd3;

	localparam cfg_idx_t CFG_BOX_WIDTH   = 3'd0;
	localparam cfg_idx_t CFG_BOX_HEIGHT  = 3'd1;
	localparam cfg_idx_t CFG_AREA_LEFT   = 3'd2;
	localparam cfg_idx_t CFG_AREA_TOP    = 3'd3;
	localparam cfg_idx_t CFG_AREA_WIDTH  = 3'd4;
	localparam cfg_idx_t CFG_AREA_HEIGHT = 3'd5;

	localparam ext_t   RST_BOX_WIDTH   = 15'd256;
	localparam ext_t   RST_BOX_HEIGHT  = 15'd512;
	localparam coord_t RST_AREA_LEFT   = 16'sd0;
	localparam coord_t RST_AREA_TOP    = 16'sd0;
	localparam ext_t   RST_AREA_WIDTH  = 15'd12800;
	localparam ext_t   RST_AREA_HEIGHT = 15'd9600;

	// One step of the per-edge schedule, kept into the next cycle to evaluate its product.
	typedef struct packed {
		logic       act;
		logic       side;
		logic [1:0] idx;
		logic [1:0] ph;
	} step_t;
endpackage
`default_nettype wire

// ----- rtl/bvs_if.sv -----
// Handshake channels of the box collision test: request, response and configuration.
// Depends on bvs_pkg.
`default_nettype none
interface bvs_req_if;
	import bvs_pkg::*;
	logic   valid;
	logic   ready;
	mode_t  mode;
	kind_t  shape_kind;
	coord_t coord_x;
	coord_t coord_y;
	ext_t   extent_a;
	ext_t   extent_b;
	modport source (output valid, mode, shape_kind, coord_x, coord_y, extent_a, extent_b,
		input ready);
	modport sink (input valid, mode, shape_kind, coord_x, coord_y, extent_a, extent_b,
		output ready);
endinterface

interface bvs_rsp_if;
	import bvs_pkg::*;
	logic     valid;
	logic     ready;
	logic     position_ok;
	verdict_t verdict;
	hit_t     hit_shape;
	total_t   shape_total;
	modport source (output valid, position_ok, verdict, hit_shape, shape_total, input ready);
	modport sink (input valid, position_ok, verdict, hit_shape, shape_total, output ready);
endinterface

interface bvs_cfg_if;
	import bvs_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  reg_index;
	cfg_data_t wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/bvs_mul.sv -----
// Shared signed multiplier of the box collision test, product registered.
// Depends on bvs_pkg.
`default_nettype none
module bvs_mul (
	input  wire            clk,
	input  bvs_pkg::opnd_t a,
	input  bvs_pkg::opnd_t b,
	output bvs_pkg::prod_t prod
);
	import bvs_pkg::*;

	prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

// ----- rtl/bvs_vmem.sv -----
// Polygon vertex store: one write port, one read port with registered read data.
// Depends on bvs_pkg.
`default_nettype none
module bvs_vmem (
	input  wire             clk,
	input  wire             we,
	input  bvs_pkg::vaddr_t waddr,
	input  bvs_pkg::vdata_t wdata,
	input  bvs_pkg::vaddr_t raddr,
	output bvs_pkg::vdata_t rdata
);
	import bvs_pkg::*;

	vdata_t mem [0:(1 << VAW) - 1];
	vdata_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/box_vs_shape_collision_test.sv -----
// Box collision test: obstacle table, sequencer and the datapath around one multiplier.
// Depends on bvs_pkg, bvs_if, bvs_mul, bvs_vmem and assert_macros.svh.
//
// Usage. Items arrive on req and each one gives exactly one response item on rsp.
// mode clears the table, adds a rectangle, circle or polygon, appends a vertex to
// the polygon last added, or queries a box of the configured size at (coord_x, coord_y).
// The cfg channel writes the six geometry registers and is always ready; write it only
// while no item is in flight.
// Sequence. Clear, add and append go from acceptance straight to ST_DONE and the output
// register. A query checks the area, then walks the shapes in table order: a rectangle
// is one overlap test, a circle takes three products, an empty polygon is skipped, and a
// polygon reads its last vertex and then each vertex in turn: every polygon edge runs a
// 25-step schedule on the single shared multiplier, two products per corner crossing
// test and three per box side.
// Throughput. One item at a time; req.ready is high only while the sequencer is idle.
// Stall. A response waits in the output register until rsp.ready; the next item is
// accepted meanwhile, but its own response waits for the register to empty.
// Reset clears the shape count and returns the registers to their documented values;
// the shape and vertex stores are not cleared and need no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module box_vs_shape_collision_test (
	input  wire clk,
	input  wire arst_n,
	bvs_req_if.sink   req,
	bvs_rsp_if.source rsp,
	bvs_cfg_if.sink   cfg
);
	import bvs_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_AREA  = 4'd1;
	localparam logic [3:0] ST_SHAPE = 4'd2;
	localparam logic [3:0] ST_RECT  = 4'd3;
	localparam logic [3:0] ST_CIRC  = 4'd4;
	localparam logic [3:0] ST_PREQ  = 4'd5;
	localparam logic [3:0] ST_PCAP  = 4'd6;
	localparam logic [3:0] ST_VREQ  = 4'd7;
	localparam logic [3:0] ST_VCAP  = 4'd8;
	localparam logic [3:0] ST_EDGE  = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	localparam logic [4:0] KLAST   = 5'd24;
	localparam logic [4:0] KSIDES  = 5'd8;

	typedef struct packed {
		opnd_t a1;
		opnd_t a2;
		opnd_t b1;
		opnd_t b2;
		opnd_t c;
		opnd_t lo;
		opnd_t hi;
	} side_t;

	// Sides 0 and 1 are the top and bottom of the box, 2 and 3 the left and right.
	function automatic side_t side_sel(input logic [1:0] idx, input opnd_t xi, input opnd_t yi,
		input opnd_t xj, input opnd_t yj, input opnd_t l, input opnd_t t, input opnd_t r,
		input opnd_t b);
		side_t s;
		if (idx[1]) begin
			s.a1 = xi; s.a2 = xj; s.b1 = yi; s.b2 = yj;
			s.c = idx[0] ? r : l; s.lo = t; s.hi = b;
		end else begin
			s.a1 = yi; s.a2 = yj; s.b1 = xi; s.b2 = xj;
			s.c = idx[0] ? b : t; s.lo = l; s.hi = r;
		end
		return s;
	endfunction

	// Configuration registers
	ext_t   bw_q, bh_q, aw_q, ah_q;
	coord_t al_q, at_q;

	// Control
	logic [3:0]      state_q;
	logic [CNTW-1:0] cnt_q;
	logic [CNTW-1:0] s_q;
	logic            last_poly_q;
	logic [VCW-1:0]  last_vcnt_q;
	logic [VIW-1:0]  vidx_q;
	logic [4:0]      k_q;
	step_t           de_s1;
	logic            out_valid_q;

	// Shape table
	kind_t          sh_kind [0:MAX_SHAPES-1];
	coord_t         sh_x    [0:MAX_SHAPES-1];
	coord_t         sh_y    [0:MAX_SHAPES-1];
	ext_t           sh_ea   [0:MAX_SHAPES-1];
	ext_t           sh_eb   [0:MAX_SHAPES-1];
	logic [VCW-1:0] sh_vcnt [0:MAX_SHAPES-1];

	// Datapath registers
	coord_t   qx_q, qy_q;
	coord_t   cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	prod_t    hold_q, num_q;
	logic     ge_q;
	logic [3:0] par_q;
	logic     vhit_q, shit_q;
	logic     res_ok_q;
	verdict_t res_verdict_q;
	hit_t     res_hit_q;
	logic     out_ok_q;
	verdict_t out_verdict_q;
	hit_t     out_hit_q;
	total_t   out_total_q;

	// Shared units
	opnd_t  ma, mb;
	prod_t  prod;
	logic   vwe;
	vaddr_t vwaddr, vraddr;
	vdata_t vwdata, vrdata;

	bvs_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(prod));

	bvs_vmem u_vmem (
		.clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(vraddr), .rdata(vrdata)
	);

	wire accept = req.valid && req.ready;
	wire [SW-1:0] last_idx = cnt_q[SW-1:0] - SW'(1);
	wire [SW-1:0] sidx = s_q[SW-1:0];

	// Query geometry
	opnd_t l, t, r, b, al, at, ar, ab;
	assign l  = opnd_t'(qx_q);
	assign t  = opnd_t'(qy_q);
	assign r  = l + opnd_t'(bw_q);
	assign b  = t + opnd_t'(bh_q);
	assign al = opnd_t'(al_q);
	assign at = opnd_t'(at_q);
	assign ar = al + opnd_t'(aw_q);
	assign ab = at + opnd_t'(ah_q);

	wire in_area = l >= al && l < ar && t >= at && t < ab &&
		r >= al && r < ar && b >= at && b < ab;

	// Current shape
	kind_t          c_kind;
	opnd_t          px, py, pea, peb;
	logic [VCW-1:0] c_n;
	assign c_kind = sh_kind[sidx];
	assign px     = opnd_t'(sh_x[sidx]);
	assign py     = opnd_t'(sh_y[sidx]);
	assign pea    = opnd_t'(sh_ea[sidx]);
	assign peb    = opnd_t'(sh_eb[sidx]);
	assign c_n    = sh_vcnt[sidx];
	wire [VIW-1:0] n_m1 = VIW'(c_n - VCW'(1));

	// Rectangle: strict overlap
	opnd_t il, ir, it, ib;
	assign il = (px > l) ? px : l;
	assign ir = ((px + pea) < r) ? (px + pea) : r;
	assign it = (py > t) ? py : t;
	assign ib = ((py + peb) < b) ? (py + peb) : b;
	wire rect_hit = il < ir && it < ib;

	// Circle: centre clamped to the box
	opnd_t cqx, cqy, dx, dy;
	always_comb begin
		cqx = (px < r) ? px : r;
		cqy = (py < b) ? py : b;
		if (cqx < l) begin
			cqx = l;
		end
		if (cqy < t) begin
			cqy = t;
		end
	end
	assign dx = px - cqx;
	assign dy = py - cqy;

	// Edge from the previous vertex (j) to the current one (i)
	opnd_t xi, yi, xj, yj;
	assign xi = opnd_t'(cur_x_q);
	assign yi = opnd_t'(cur_y_q);
	assign xj = opnd_t'(prev_x_q);
	assign yj = opnd_t'(prev_y_q);
	wire opnd_t dyij = yj - yi;

	step_t ds;
	logic [4:0] km;
	always_comb begin
		km      = k_q - KSIDES;
		ds.side = k_q >= KSIDES;
		ds.idx  = ds.side ? km[3:2] : k_q[2:1];
		ds.ph   = ds.side ? km[1:0] : {1'b0, k_q[0]};
		ds.act  = (state_q == ST_EDGE) && (k_q < KLAST) && (ds.ph != 2'd3);
	end

	side_t si, se;
	assign si = side_sel(ds.idx, xi, yi, xj, yj, l, t, r, b);
	assign se = side_sel(de_s1.idx, xi, yi, xj, yj, l, t, r, b);
	wire opnd_t den_i  = si.a2 - si.a1;
	wire        neg_i  = den_i < 0;
	wire opnd_t aden_i = neg_i ? -den_i : den_i;

	opnd_t cpx_i, cpy_i, cpy_e;
	assign cpx_i = (ds.idx == 2'd0 || ds.idx == 2'd3) ? l : r;
	assign cpy_i = ds.idx[1] ? b : t;
	assign cpy_e = de_s1.idx[1] ? b : t;

	always_comb begin
		ma = '0;
		mb = '0;
		if (state_q == ST_CIRC) begin
			case (k_q[1:0])
				2'd0: begin ma = dx;  mb = dx;  end
				2'd1: begin ma = dy;  mb = dy;  end
				2'd2: begin ma = pea; mb = pea; end
				default: begin ma = '0; mb = '0; end
			endcase
		end else if (ds.act) begin
			if (!ds.side) begin
				if (ds.ph[0]) begin
					ma = xj - xi; mb = cpy_i - yi;
				end else begin
					ma = cpx_i - xi; mb = dyij;
				end
			end else begin
				case (ds.ph)
					2'd0: begin ma = neg_i ? (si.a1 - si.c) : (si.c - si.a1); mb = si.b2 - si.b1; end
					2'd1: begin ma = si.lo - si.b1; mb = aden_i; end
					2'd2: begin ma = si.hi - si.b1; mb = aden_i; end
					default: begin ma = '0; mb = '0; end
				endcase
			end
		end
	end

	// Evaluation of the product issued in the previous cycle
	wire corner_cond = (yi > cpy_e) != (yj > cpy_e);
	wire corner_cross = (dyij > 0) ? (hold_q < prod) : (hold_q > prod);
	wire side_guard = ((se.a1 <= se.c && se.a2 >= se.c) || (se.a2 <= se.c && se.a1 >= se.c)) &&
		(se.a1 != se.a2);
	wire cur_in_box = xi >= l && xi < r && yi >= t && yi < b;
	wire poly_hit = vhit_q || shit_q || (c_n >= VCW'(POLY_MIN_VERTS) && (|par_q));

	always_comb begin
		vwe    = 1'b0;
		vwaddr = {last_idx, last_vcnt_q[VIW-1:0]};
		vwdata = {req.coord_y, req.coord_x};
		if (state_q == ST_IDLE && accept && req.mode == MODE_APPEND && cnt_q != '0 &&
			last_poly_q && last_vcnt_q < VCW'(MAX_VERTS)) begin
			vwe = 1'b1;
		end
		vraddr = {sidx, (state_q == ST_PREQ) ? n_m1 : vidx_q};
	end

	assign req.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= RST_BOX_WIDTH;
			bh_q <= RST_BOX_HEIGHT;
			al_q <= RST_AREA_LEFT;
			at_q <= RST_AREA_TOP;
			aw_q <= RST_AREA_WIDTH;
			ah_q <= RST_AREA_HEIGHT;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_BOX_WIDTH:   bw_q <= cfg.wdata[14:0];
				CFG_BOX_HEIGHT:  bh_q <= cfg.wdata[14:0];
				CFG_AREA_LEFT:   al_q <= coord_t'(cfg.wdata);
				CFG_AREA_TOP:    at_q <= coord_t'(cfg.wdata);
				CFG_AREA_WIDTH:  aw_q <= cfg.wdata[14:0];
				CFG_AREA_HEIGHT: ah_q <= cfg.wdata[14:0];
				default: ;
			endcase
		end
	end

	// Table writes; the stores themselves have no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			if (req.mode == MODE_ADD && req.shape_kind <= KIND_POLY &&
				cnt_q < CNTW'(MAX_SHAPES)) begin
				sh_kind[cnt_q[SW-1:0]] <= req.shape_kind;
				sh_x[cnt_q[SW-1:0]]    <= req.coord_x;
				sh_y[cnt_q[SW-1:0]]    <= req.coord_y;
				sh_ea[cnt_q[SW-1:0]]   <= req.extent_a;
				sh_eb[cnt_q[SW-1:0]]   <= req.extent_b;
				sh_vcnt[cnt_q[SW-1:0]] <= '0;
			end
			if (vwe) begin
				sh_vcnt[last_idx] <= last_vcnt_q + VCW'(1);
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			s_q           <= '0;
			last_poly_q   <= 1'b0;
			last_vcnt_q   <= '0;
			vidx_q        <= '0;
			k_q           <= '0;
			de_s1         <= '0;
			res_ok_q      <= 1'b0;
			res_verdict_q <= VERDICT_OK;
			res_hit_q     <= '0;
			qx_q          <= '0;
			qy_q          <= '0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			hold_q        <= '0;
			num_q         <= '0;
			ge_q          <= 1'b0;
			par_q         <= '0;
			vhit_q        <= 1'b0;
			shit_q        <= 1'b0;
		end else begin
			de_s1 <= ds;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_ok_q      <= 1'b0;
						res_verdict_q <= VERDICT_OK;
						res_hit_q     <= '0;
						qx_q          <= req.coord_x;
						qy_q          <= req.coord_y;
						state_q       <= ST_DONE;
						case (req.mode)
							MODE_CLEAR: begin
								cnt_q <= '0;
							end
							MODE_ADD: begin
								if (req.shape_kind > KIND_POLY || cnt_q >= CNTW'(MAX_SHAPES)) begin
									res_verdict_q <= VERDICT_OVERFLOW;
								end else begin
									cnt_q       <= cnt_q + CNTW'(1);
									last_poly_q <= req.shape_kind == KIND_POLY;
									last_vcnt_q <= '0;
								end
							end
							MODE_APPEND: begin
								if (vwe) begin
									last_vcnt_q <= last_vcnt_q + VCW'(1);
								end else begin
									res_verdict_q <= VERDICT_OVERFLOW;
								end
							end
							default: begin
								state_q <= ST_AREA;
							end
						endcase
					end
				end
				ST_AREA: begin
					s_q <= '0;
					if (in_area) begin
						state_q <= ST_SHAPE;
					end else begin
						res_verdict_q <= VERDICT_OUTSIDE;
						state_q       <= ST_DONE;
					end
				end
				ST_SHAPE: begin
					k_q    <= '0;
					vidx_q <= '0;
					vhit_q <= 1'b0;
					shit_q <= 1'b0;
					par_q  <= '0;
					if (s_q == cnt_q) begin
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						case (c_kind)
							KIND_RECT:   state_q <= ST_RECT;
							KIND_CIRCLE: state_q <= ST_CIRC;
							KIND_POLY: begin
								if (c_n == '0) begin
									s_q <= s_q + CNTW'(1);
								end else begin
									state_q <= ST_PREQ;
								end
							end
							default: s_q <= s_q + CNTW'(1);
						endcase
					end
				end
				ST_RECT: begin
					if (rect_hit) begin
						res_verdict_q <= VERDICT_HIT;
						res_hit_q     <= hit_t'(s_q);
						state_q       <= ST_DONE;
					end else begin
						s_q     <= s_q + CNTW'(1);
						state_q <= ST_SHAPE;
					end
				end
				ST_CIRC: begin
					k_q <= k_q + 5'd1;
					case (k_q[1:0])
						2'd1: hold_q <= prod;
						2'd2: hold_q <= hold_q + prod;
						2'd3: begin
							if (hold_q <= prod) begin
								res_verdict_q <= VERDICT_HIT;
								res_hit_q     <= hit_t'(s_q);
								state_q       <= ST_DONE;
							end else begin
								s_q     <= s_q + CNTW'(1);
								state_q <= ST_SHAPE;
							end
						end
						default: ;
					endcase
				end
				ST_PREQ: state_q <= ST_PCAP;
				ST_PCAP: begin
					prev_x_q <= coord_t'(vrdata[15:0]);
					prev_y_q <= coord_t'(vrdata[31:16]);
					state_q  <= ST_VREQ;
				end
				ST_VREQ: state_q <= ST_VCAP;
				ST_VCAP: begin
					cur_x_q <= coord_t'(vrdata[15:0]);
					cur_y_q <= coord_t'(vrdata[31:16]);
					k_q     <= '0;
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					k_q <= k_q + 5'd1;
					if (k_q == '0 && cur_in_box) begin
						vhit_q <= 1'b1;
					end
					if (de_s1.act) begin
						if (!de_s1.side) begin
							if (!de_s1.ph[0]) begin
								hold_q <= prod;
							end else if (corner_cond && corner_cross) begin
								par_q[de_s1.idx] <= ~par_q[de_s1.idx];
							end
						end else begin
							case (de_s1.ph)
								2'd0: num_q <= prod;
								2'd1: ge_q  <= num_q >= prod;
								2'd2: begin
									if (side_guard && ge_q && num_q <= prod) begin
										shit_q <= 1'b1;
									end
								end
								default: ;
							endcase
						end
					end
					if (k_q == KLAST) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						if (vidx_q == n_m1) begin
							if (poly_hit) begin
								res_verdict_q <= VERDICT_HIT;
								res_hit_q     <= hit_t'(s_q);
								state_q       <= ST_DONE;
							end else begin
								s_q     <= s_q + CNTW'(1);
								state_q <= ST_SHAPE;
							end
						end else begin
							vidx_q  <= vidx_q + VIW'(1);
							state_q <= ST_VREQ;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
			out_ok_q      <= res_ok_q;
			out_verdict_q <= res_verdict_q;
			out_hit_q     <= res_hit_q;
			out_total_q   <= total_t'(cnt_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.position_ok = out_ok_q;
	assign rsp.verdict     = out_verdict_q;
	assign rsp.hit_shape   = out_hit_q;
	assign rsp.shape_total = out_total_q;

	`BVS_ASSERT(a_count_bound, cnt_q <= CNTW'(MAX_SHAPES))
	`BVS_ASSERT(a_step_bound, (state_q == ST_EDGE) |-> (k_q <= KLAST))
	`BVS_ASSERT(a_vertex_bound, (state_q == ST_EDGE) |-> (VCW'(vidx_q) < c_n))
	`BVS_ASSERT(a_one_at_a_time, (req.valid && req.ready) |=> !req.ready)
endmodule
`default_nettype wire

// ----- tb/bvs_test_if.sv -----
// Note: interfaces come from the RTL (bvs_if.sv); this file holds the testbench's shared helpers.
// Depends on bvs_pkg.
`default_nettype none
package bvs_test_pkg;
	import bvs_pkg::*;
	typedef struct packed {
		logic     position_ok;
		verdict_t verdict;
		hit_t     hit_shape;
		total_t   shape_total;
	} bvs_result_t;
endpackage
`default_nettype wire

// ----- tb/bvs_checker.sv -----
// Checker for the box collision test: watches the request, response and configuration
// channels, predicts each result from its own copy of the obstacle table and compares.
// Depends on bvs_pkg, bvs_test_pkg and the RTL interfaces.
`default_nettype none
module bvs_checker
	import bvs_pkg::*;
	import bvs_test_pkg::*;
(
	input  wire clk,
	input  wire arst_n,
	bvs_req_if.sink req,
	bvs_rsp_if.sink rsp,
	bvs_cfg_if.sink cfg,
	output int      errors,
	output int      pending,
	output logic    any_accept
);
	timeunit 1ns;
	timeprecision 1ps;

	longint box_w, box_h, ar_left, ar_top, ar_w, ar_h;
	int     n_shapes;
	kind_t  kinds [MAX_SHAPES];
	longint sh_x [MAX_SHAPES], sh_y [MAX_SHAPES], sh_a [MAX_SHAPES], sh_b [MAX_SHAPES];
	int     n_verts [MAX_SHAPES];
	longint v_x [MAX_SHAPES][MAX_VERTS], v_y [MAX_SHAPES][MAX_VERTS];
	bvs_result_t expected_results[$];

	function automatic bit crosses_side(longint a1, longint b1, longint a2, longint b2,
		longint c, longint lo, longint hi);
		longint num, den;
		if (!((a1 <= c && a2 >= c) || (a2 <= c && a1 >= c))) return 0;
		if (a1 == a2) return 0;
		num = (c - a1) * (b2 - b1);
		den = a2 - a1;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		return num >= (lo - b1) * den && num <= (hi - b1) * den;
	endfunction

	function automatic bit corner_inside(int s, longint px, longint py);
		bit odd;
		int j;
		longint d, lhs, rhs;
		odd = 0;
		if (n_verts[s] < POLY_MIN_VERTS) return 0;
		j = n_verts[s] - 1;
		for (int i = 0; i < n_verts[s]; i++) begin
			if ((v_y[s][i] > py) != (v_y[s][j] > py)) begin
				d = v_y[s][j] - v_y[s][i];
				lhs = (px - v_x[s][i]) * d;
				rhs = (v_x[s][j] - v_x[s][i]) * (py - v_y[s][i]);
				if (d > 0 ? lhs < rhs : lhs > rhs) odd = !odd;
			end
			j = i;
		end
		return odd;
	endfunction

	function automatic bit polygon_touches(int s, longint l, longint t, longint r, longint b);
		int n, j;
		n = n_verts[s];
		if (n == 0) return 0;
		for (int i = 0; i < n; i++)
			if (v_x[s][i] >= l && v_x[s][i] < r && v_y[s][i] >= t && v_y[s][i] < b) return 1;
		if (corner_inside(s, l, t) || corner_inside(s, r, t) || corner_inside(s, r, b)
			|| corner_inside(s, l, b)) return 1;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			if (crosses_side(v_y[s][i], v_x[s][i], v_y[s][j], v_x[s][j], t, l, r)) return 1;
			if (crosses_side(v_y[s][i], v_x[s][i], v_y[s][j], v_x[s][j], b, l, r)) return 1;
			if (crosses_side(v_x[s][i], v_y[s][i], v_x[s][j], v_y[s][j], l, t, b)) return 1;
			if (crosses_side(v_x[s][i], v_y[s][i], v_x[s][j], v_y[s][j], r, t, b)) return 1;
		end
		return 0;
	endfunction

	function automatic bit shape_touches(int s, longint l, longint t, longint r, longint b);
		longint il, ir, it, ib, qx, qy;
		case (kinds[s])
			KIND_RECT: begin
				il = sh_x[s] > l ? sh_x[s] : l;
				ir = (sh_x[s] + sh_a[s]) < r ? sh_x[s] + sh_a[s] : r;
				it = sh_y[s] > t ? sh_y[s] : t;
				ib = (sh_y[s] + sh_b[s]) < b ? sh_y[s] + sh_b[s] : b;
				return il < ir && it < ib;
			end
			KIND_CIRCLE: begin
				qx = sh_x[s] < r ? sh_x[s] : r;
				qy = sh_y[s] < b ? sh_y[s] : b;
				if (qx < l) qx = l;
				if (qy < t) qy = t;
				return (sh_x[s] - qx) ** 2 + (sh_y[s] - qy) ** 2 <= sh_a[s] * sh_a[s];
			end
			KIND_POLY: return polygon_touches(s, l, t, r, b);
			default: return 0;
		endcase
	endfunction

	function automatic bvs_result_t predict_collision(mode_t m, kind_t k, coord_t x, coord_t y,
		ext_t ea, ext_t eb);
		bvs_result_t res;
		longint l, t, r, b, ar, ab;
		int s;
		res = '0;
		case (m)
			MODE_CLEAR: n_shapes = 0;
			MODE_ADD: begin
				if (k > KIND_POLY || n_shapes >= MAX_SHAPES) res.verdict = VERDICT_OVERFLOW;
				else begin
					kinds[n_shapes] = k;
					sh_x[n_shapes] = x;
					sh_y[n_shapes] = y;
					sh_a[n_shapes] = ea;
					sh_b[n_shapes] = eb;
					n_verts[n_shapes] = 0;
					n_shapes++;
				end
			end
			MODE_APPEND: begin
				s = n_shapes - 1;
				if (n_shapes == 0 || kinds[s] != KIND_POLY || n_verts[s] >= MAX_VERTS)
					res.verdict = VERDICT_OVERFLOW;
				else begin
					v_x[s][n_verts[s]] = x;
					v_y[s][n_verts[s]] = y;
					n_verts[s]++;
				end
			end
			default: begin
				l = x;
				t = y;
				r = l + box_w;
				b = t + box_h;
				ar = ar_left + ar_w;
				ab = ar_top + ar_h;
				if (!(l >= ar_left && l < ar && t >= ar_top && t < ab && r >= ar_left && r < ar
					&& b >= ar_top && b < ab)) res.verdict = VERDICT_OUTSIDE;
				else begin
					for (s = 0; s < n_shapes; s++)
						if (shape_touches(s, l, t, r, b)) begin
							res.verdict = VERDICT_HIT;
							res.hit_shape = hit_t'(s);
							break;
						end
					res.position_ok = res.verdict == VERDICT_OK;
				end
			end
		endcase
		res.shape_total = total_t'(n_shapes);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("error at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		bvs_result_t want;
		if (!arst_n) begin
			box_w <= RST_BOX_WIDTH;
			box_h <= RST_BOX_HEIGHT;
			ar_left <= RST_AREA_LEFT;
			ar_top <= RST_AREA_TOP;
			ar_w <= RST_AREA_WIDTH;
			ar_h <= RST_AREA_HEIGHT;
			n_shapes = 0;
			errors <= 0;
			any_accept <= 0;
			expected_results.delete();
		end else begin
			any_accept <= (req.valid && req.ready) || (rsp.valid && rsp.ready);
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					CFG_BOX_WIDTH:   box_w <= cfg.wdata[14:0];
					CFG_BOX_HEIGHT:  box_h <= cfg.wdata[14:0];
					CFG_AREA_LEFT:   ar_left <= coord_t'(cfg.wdata);
					CFG_AREA_TOP:    ar_top <= coord_t'(cfg.wdata);
					CFG_AREA_WIDTH:  ar_w <= cfg.wdata[14:0];
					CFG_AREA_HEIGHT: ar_h <= cfg.wdata[14:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result items", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (rsp.position_ok !== want.position_ok)
						report_mismatch("position_ok", rsp.position_ok, want.position_ok);
					if (rsp.verdict !== want.verdict)
						report_mismatch("verdict", rsp.verdict, want.verdict);
					if (rsp.hit_shape !== want.hit_shape)
						report_mismatch("hit_shape", rsp.hit_shape, want.hit_shape);
					if (rsp.shape_total !== want.shape_total)
						report_mismatch("shape_total", rsp.shape_total, want.shape_total);
				end
			end
			if (req.valid && req.ready)
				expected_results.insert(expected_results.size(), predict_collision(req.mode,
					req.shape_kind, req.coord_x, req.coord_y, req.extent_a, req.extent_b));
		end
	end
endmodule
`default_nettype wire

// ----- tb/box_vs_shape_collision_test_test.sv -----
// Top of the box collision test bench: clock, reset, stimulus and verdict.
// Depends on bvs_pkg, the RTL interfaces, bvs_checker and the block itself.
`default_nettype none
module box_vs_shape_collision_test_test;
	import bvs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	int   errors, pending;
	logic any_accept;
	int   send_idle_pct = 0, recv_idle_pct = 0;
	bit   hold_off = 0;
	int   quiet_cycles = 0;

	bvs_req_if req ();
	bvs_rsp_if rsp ();
	bvs_cfg_if cfg ();

	box_vs_shape_collision_test u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg));
	bvs_checker u_checker (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.errors(errors), .pending(pending), .any_accept(any_accept));

	always #5 clk = ~clk;

	initial begin
		req.valid = 0;
		req.mode = MODE_CLEAR;
		req.shape_kind = KIND_RECT;
		req.coord_x = 0;
		req.coord_y = 0;
		req.extent_a = 0;
		req.extent_b = 0;
		rsp.ready = 0;
		cfg.valid = 0;
		cfg.reg_index = CFG_BOX_WIDTH;
		cfg.wdata = 0;
	end

	// The receiver side runs on its own, throttled by the current phase or a hold-off.
	always @(posedge clk) begin
		if (!arst_n || hold_off) rsp.ready <= 0;
		else rsp.ready <= $urandom_range(99) >= recv_idle_pct;
	end

	always @(posedge clk) begin
		if (any_accept) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Leaves valid high after the item; the next item or drain_block takes it over.
	task automatic send_item(mode_t m, kind_t k, coord_t x, coord_t y, ext_t a, ext_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.mode <= m;
		req.shape_kind <= k;
		req.coord_x <= x;
		req.coord_y <= y;
		req.extent_a <= a;
		req.extent_b <= b;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic write_register(cfg_idx_t idx, cfg_data_t val);
		cfg.valid <= 1;
		cfg.reg_index <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Stops offering items and waits for every expected result to come out.
	task automatic drain_block();
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_geometry(ext_t bw, ext_t bh, coord_t al, coord_t at, ext_t aw, ext_t ah);
		drain_block();
		write_register(CFG_BOX_WIDTH, {1'b0, bw});
		write_register(CFG_BOX_HEIGHT, {1'b0, bh});
		write_register(CFG_AREA_LEFT, al);
		write_register(CFG_AREA_TOP, at);
		write_register(CFG_AREA_WIDTH, {1'b0, aw});
		write_register(CFG_AREA_HEIGHT, {1'b0, ah});
		cfg.valid <= 0;
	endtask

	function automatic coord_t near_coord();
		return coord_t'($signed($urandom_range(14000)) - 1000);
	endfunction

	// Builds a random table of mixed rectangles, circles and polygons near the play area.
	task automatic random_table(int n);
		int nv;
		send_item(MODE_CLEAR, KIND_RECT, 0, 0, 0, 0);
		for (int s = 0; s < n; s++) begin
			case ($urandom_range(2))
				0: send_item(MODE_ADD, KIND_RECT, near_coord(), near_coord(),
					ext_t'($urandom_range(3000)), ext_t'($urandom_range(3000)));
				1: send_item(MODE_ADD, KIND_CIRCLE, near_coord(), near_coord(),
					ext_t'($urandom_range(1500)), ext_t'($urandom));
				default: begin
					send_item(MODE_ADD, KIND_POLY, coord_t'($urandom), coord_t'($urandom),
						ext_t'($urandom), ext_t'($urandom));
					nv = $urandom_range(9);
					for (int v = 0; v < nv; v++)
						send_item(MODE_APPEND, KIND_RECT, near_coord(), near_coord(),
							ext_t'($urandom), ext_t'($urandom));
				end
			endcase
		end
	endtask

	task automatic random_queries(int n);
		for (int i = 0; i < n; i++)
			if ($urandom_range(19) == 0)
				send_item(mode_t'($urandom), kind_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), ext_t'($urandom), ext_t'($urandom));
			else
				send_item(MODE_QUERY, KIND_RECT, near_coord(), near_coord(), ext_t'($urandom),
					ext_t'($urandom));
	endtask

	task automatic random_phase(int rounds);
		for (int i = 0; i < rounds; i++) begin
			random_table($urandom_range(1, 17));
			random_queries($urandom_range(3, 10));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: every mode, overflows, empty and short polygons, area edges.
		send_item(MODE_APPEND, KIND_RECT, 0, 0, 0, 0);
		send_item(MODE_ADD, kind_t'(3), 0, 0, 0, 0);
		send_item(MODE_QUERY, KIND_RECT, 0, 0, 0, 0);
		send_item(MODE_QUERY, KIND_RECT, -16'sd32768, 16'sd32767, 15'h7fff, 15'h7fff);
		send_item(MODE_QUERY, KIND_RECT, 12544, 9088, 0, 0);
		send_item(MODE_QUERY, KIND_RECT, 12545, 9088, 0, 0);
		send_item(MODE_ADD, KIND_RECT, 1000, 1000, 500, 500);
		send_item(MODE_APPEND, KIND_RECT, 0, 0, 0, 0);
		send_item(MODE_ADD, KIND_CIRCLE, 3000, 3000, 200, 15'h7fff);
		send_item(MODE_ADD, KIND_POLY, 0, 0, 0, 0);
		send_item(MODE_QUERY, KIND_RECT, 5000, 5000, 0, 0);
		send_item(MODE_APPEND, KIND_RECT, 6000, 6000, 0, 0);
		send_item(MODE_APPEND, KIND_RECT, 6000, 7000, 0, 0);
		send_item(MODE_QUERY, KIND_RECT, 5900, 6500, 0, 0);
		send_item(MODE_APPEND, KIND_RECT, 7000, 6500, 0, 0);
		for (int v = 0; v < 6; v++)
			send_item(MODE_APPEND, KIND_RECT, 16'sd32767, -16'sd32768, 0, 0);
		send_item(MODE_QUERY, KIND_RECT, 6200, 6400, 0, 0);
		send_item(MODE_QUERY, KIND_RECT, 700, 700, 0, 0);
		send_item(MODE_QUERY, KIND_RECT, 2900, 2500, 0, 0);
		send_item(MODE_CLEAR, KIND_RECT, 0, 0, 0, 0);

		random_phase(4);
		send_idle_pct = 72;
		random_phase(3);
		send_idle_pct = 0;
		recv_idle_pct = 72;
		random_phase(3);

		set_geometry(0, 0, -16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff);
		send_idle_pct = 23;
		recv_idle_pct = 23;
		random_phase(3);
		set_geometry(15'h7fff, 15'h7fff, 16'sd32767, 16'sd32767, 0, 0);
		random_phase(1);
		set_geometry(64, 64, -16'sd1000, -16'sd1000, 15'd16000, 15'd12000);
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// Long receiver hold-off while items keep coming, so the input stalls.
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			random_queries(6);
		join
		random_phase(4);

		drain_block();
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/bvs_pkg.sv
rtl/bvs_if.sv
rtl/bvs_mul.sv
rtl/bvs_vmem.sv
rtl/box_vs_shape_collision_test.sv
tb/bvs_test_if.sv
tb/bvs_checker.sv
tb/box_vs_shape_collision_test_test.sv
